FILE: rtl/scanline_sprite_evaluation_unit_defines.svh
// Assertion macros for the sprite evaluation block.
`ifndef SCANLINE_SPRITE_EVALUATION_UNIT_DEFINES_SVH
`define SCANLINE_SPRITE_EVALUATION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SSE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sse_pkg.sv
package sse_pkg;

  localparam int SPRITE_ENTRIES = 64;
  localparam int LINE_SLOTS     = 8;

  localparam int ENTRY_W    = $clog2(SPRITE_ENTRIES);
  localparam int FOUND_W    = $clog2(LINE_SLOTS + 1);
  localparam int SLOT_IDX_W = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
  localparam int RECORDS    = (LINE_SLOTS < 8) ? LINE_SLOTS : 8;

  localparam logic [7:0] ATTR_KEEP_MASK = 8'hE3;
  localparam logic [7:0] EMPTY_BYTE     = 8'hFF;
  localparam logic [1:0] ATTR_OFFSET    = 2'd2;
  localparam logic [8:0] SHORT_HEIGHT   = 9'd8;
  localparam logic [8:0] TALL_HEIGHT    = 9'd16;

  localparam logic [1:0] ACT_SET_ADDR = 2'd0;
  localparam logic [1:0] ACT_WRITE    = 2'd1;
  localparam logic [1:0] ACT_READ     = 2'd2;
  localparam logic [1:0] ACT_EVAL     = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [7:0] line_number;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] read_data;
    logic [2:0] slot_index;
    logic [7:0] sprite_top;
    logic [7:0] tile_number;
    logic [7:0] attribute_bits;
    logic [7:0] sprite_left;
    logic       slot_used;
    logic [3:0] sprites_found;
    logic       overflow;
    logic       first_entry_in_range;
    logic       last;
  } rsp_t;

  // byte 0 Y, 1 tile, 2 attribute, 3 X
  typedef logic [3:0][7:0] slot_t;

  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    logic [1:0]            sel;
    logic [7:0]            data;
  } slot_wr_t;

  function automatic logic [7:0] byte_addr(input logic [ENTRY_W-1:0] entry,
                                           input logic [1:0] sel);
    byte_addr = 8'({entry, sel});
  endfunction

endpackage

FILE: rtl/sse_ram.sv
module sse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/sse_range_cmp.sv
module sse_range_cmp (
  input  logic [7:0] line_number,
  input  logic [7:0] y_byte,
  input  logic       tall,
  output logic       hit
);

  logic [8:0] y_end;

  // range end taken without wrap
  assign y_end = {1'b0, y_byte} + (tall ? sse_pkg::TALL_HEIGHT : sse_pkg::SHORT_HEIGHT);
  assign hit   = (line_number >= y_byte) && ({1'b0, line_number} < y_end);

endmodule

FILE: rtl/sse_slot_store.sv
module sse_slot_store (
  input  logic                           clk,
  input  sse_pkg::slot_wr_t              wr,
  input  logic [sse_pkg::SLOT_IDX_W-1:0] rd_idx,
  output sse_pkg::slot_t                 rd_slot
);

  sse_pkg::slot_t slots [sse_pkg::LINE_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      slots[wr.idx][wr.sel] <= wr.data;
    end
  end

  assign rd_slot = slots[rd_idx];

endmodule

FILE: rtl/scanline_sprite_evaluation_unit.sv
// Set address / write byte: no result beat. Read byte: the result beat is registered
// in the read state once the output register is free; no new command is taken until then.
// Evaluate: one entry compared per cycle outside the fetch state, which copies the
// other three bytes of each placed sprite; the scan ends at the last entry or a
// ninth match; then 8 record beats. Reset (synchronous, rst high): a clearing pass
// zeroes all 256 sprite memory bytes; cmd_stall stays high until it ends.
`include "scanline_sprite_evaluation_unit_defines.svh"

module scanline_sprite_evaluation_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  sse_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sse_pkg::rsp_t rsp,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]                    state;
  logic [7:0]                    memory_address;
  logic                          tall;
  logic [7:0]                    clr_cnt;
  logic [sse_pkg::ENTRY_W-1:0]   entry;
  logic [1:0]                    byte_sel;
  logic [sse_pkg::FOUND_W-1:0]   found;
  logic                          overflow;
  logic                          first_hit;
  logic [7:0]                    line;
  logic [2:0]                    emit_k;

  logic                          cmd_accept;
  logic                          rsp_take;
  logic                          rsp_free;
  logic                          rsp_load;
  logic                          ram_we;
  logic [7:0]                    ram_addr;
  logic [7:0]                    ram_wdata;
  logic [7:0]                    ram_rdata;
  logic                          hit;
  logic                          room;
  logic                          last_entry;
  logic                          last_rec;
  logic [sse_pkg::ENTRY_W-1:0]   entry_inc;
  sse_pkg::slot_wr_t             slot_wr;
  sse_pkg::slot_t                rd_slot;
  sse_pkg::rsp_t                 read_rsp;
  sse_pkg::rsp_t                 slot_rsp;
  logic                          k_used;

  assign cmd_stall  = (state != S_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign rsp_take   = rsp_valid && !rsp_stall;
  assign rsp_free   = !rsp_valid || rsp_take;
  assign rsp_load   = rsp_free && ((state == S_RD) || (state == S_EMIT));

  assign room       = (found != sse_pkg::FOUND_W'(sse_pkg::LINE_SLOTS));
  assign last_entry = (entry == sse_pkg::ENTRY_W'(sse_pkg::SPRITE_ENTRIES - 1));
  assign last_rec   = (emit_k == 3'(sse_pkg::RECORDS - 1));
  assign entry_inc  = sse_pkg::ENTRY_W'(entry + 1'b1);

  sse_ram #(.WIDTH(8), .DEPTH(256)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  sse_range_cmp u_cmp (
    .line_number (line),
    .y_byte      (ram_rdata),
    .tall        (tall),
    .hit         (hit)
  );

  sse_slot_store u_slots (
    .clk     (clk),
    .wr      (slot_wr),
    .rd_idx  (sse_pkg::SLOT_IDX_W'(emit_k)),
    .rd_slot (rd_slot)
  );

  // memory port: the next read address is set up ahead, since the read data is registered
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = memory_address;
    ram_wdata = cmd.data_byte;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt;
        ram_wdata = 8'h00;
      end
      S_IDLE: begin
        if (cmd_accept && (cmd.action == sse_pkg::ACT_WRITE)) begin
          ram_we = 1'b1;
        end else if (cmd_accept && (cmd.action == sse_pkg::ACT_EVAL)) begin
          ram_addr = 8'h00;
        end
      end
      S_CHECK: begin
        if (hit && room) begin
          ram_addr = sse_pkg::byte_addr(entry, 2'd1);
        end else begin
          ram_addr = sse_pkg::byte_addr(entry_inc, 2'd0);
        end
      end
      S_FETCH: begin
        if (byte_sel != 2'd3) begin
          ram_addr = sse_pkg::byte_addr(entry, 2'(byte_sel + 1'b1));
        end else begin
          ram_addr = sse_pkg::byte_addr(entry_inc, 2'd0);
        end
      end
      default: begin
        ram_addr = memory_address;
      end
    endcase
  end

  always_comb begin
    slot_wr.en   = 1'b0;
    slot_wr.idx  = found[sse_pkg::SLOT_IDX_W-1:0];
    slot_wr.sel  = byte_sel;
    slot_wr.data = ram_rdata;
    if (state == S_CHECK) begin
      slot_wr.en  = hit && room;
      slot_wr.sel = 2'd0;
    end else if (state == S_FETCH) begin
      slot_wr.en  = 1'b1;
    end
  end

  always_comb begin
    read_rsp           = '0;
    read_rsp.kind      = 1'b0;
    read_rsp.read_data = (memory_address[1:0] == sse_pkg::ATTR_OFFSET)
                         ? (ram_rdata & sse_pkg::ATTR_KEEP_MASK) : ram_rdata;
    read_rsp.last      = 1'b1;
  end

  assign k_used = (5'(emit_k) < 5'(found));

  always_comb begin
    slot_rsp                      = '0;
    slot_rsp.kind                 = 1'b1;
    slot_rsp.slot_index           = emit_k;
    slot_rsp.sprite_top           = k_used ? rd_slot[0] : sse_pkg::EMPTY_BYTE;
    slot_rsp.tile_number          = k_used ? rd_slot[1] : sse_pkg::EMPTY_BYTE;
    slot_rsp.attribute_bits       = k_used ? rd_slot[2] : sse_pkg::EMPTY_BYTE;
    slot_rsp.sprite_left          = k_used ? rd_slot[3] : sse_pkg::EMPTY_BYTE;
    slot_rsp.slot_used            = k_used;
    slot_rsp.sprites_found        = 4'(found);
    slot_rsp.overflow             = overflow;
    slot_rsp.first_entry_in_range = first_hit;
    slot_rsp.last                 = last_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_cnt        <= 8'h00;
      memory_address <= 8'h00;
      tall           <= 1'b0;
      rsp_valid      <= 1'b0;
      entry          <= '0;
      byte_sel       <= 2'd0;
      found          <= '0;
      overflow       <= 1'b0;
      first_hit      <= 1'b0;
      emit_k         <= 3'd0;
    end else begin
      if (cfg_wr_en) begin
        tall <= cfg_wr_data;
      end
      if (rsp_take && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= 8'(clr_cnt + 1'b1);
          if (clr_cnt == 8'hFF) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_accept) begin
            unique case (cmd.action)
              sse_pkg::ACT_SET_ADDR: memory_address <= cmd.data_byte;
              sse_pkg::ACT_WRITE:    memory_address <= 8'(memory_address + 1'b1);
              sse_pkg::ACT_READ:     state <= S_RD;
              sse_pkg::ACT_EVAL: begin
                line      <= cmd.line_number;
                entry     <= '0;
                found     <= '0;
                overflow  <= 1'b0;
                first_hit <= 1'b0;
                state     <= S_CHECK;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RD: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            rsp       <= read_rsp;
            state     <= S_IDLE;
          end
        end
        S_CHECK: begin
          if (hit && room) begin
            if (entry == '0) begin
              first_hit <= 1'b1;
            end
            byte_sel <= 2'd1;
            state    <= S_FETCH;
          end else if (hit) begin
            // a match with every slot taken ends the scan
            overflow <= 1'b1;
            emit_k   <= 3'd0;
            state    <= S_EMIT;
          end else if (last_entry) begin
            emit_k <= 3'd0;
            state  <= S_EMIT;
          end else begin
            entry <= entry_inc;
          end
        end
        S_FETCH: begin
          if (byte_sel == 2'd3) begin
            found <= sse_pkg::FOUND_W'(found + 1'b1);
            if (last_entry) begin
              emit_k <= 3'd0;
              state  <= S_EMIT;
            end else begin
              entry <= entry_inc;
              state <= S_CHECK;
            end
          end else begin
            byte_sel <= 2'(byte_sel + 1'b1);
          end
        end
        S_EMIT: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            rsp       <= slot_rsp;
            if (last_rec) begin
              state <= S_IDLE;
            end else begin
              emit_k <= 3'(emit_k + 1'b1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SSE_ASSERT_IMPL(a_ovf_full, clk, rst, overflow, found == sse_pkg::FOUND_W'(sse_pkg::LINE_SLOTS), "overflow raised with free slots")
  `SSE_ASSERT_IMPL(a_empty_ff, clk, rst, rsp_valid && rsp.kind && !rsp.slot_used, rsp.sprite_top == sse_pkg::EMPTY_BYTE, "unused slot record not filled with 0xFF")
  `SSE_ASSERT_IMPL(a_read_last, clk, rst, rsp_valid && !rsp.kind, rsp.last && (rsp.slot_index == 3'd0), "read beat not a single last beat")
  `SSE_ASSERT_NEXT(a_clear_quiet, clk, rst, state == S_CLEAR, !rsp_valid, "result beat during clearing pass")

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 16;
  localparam int IDLE_PCT       = 29;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 42;

  logic          clk         = 1'b0;
  logic          rst         = 1'b1;
  logic          cmd_valid   = 1'b0;
  logic          cmd_stall;
  sse_pkg::cmd_t cmd         = '0;
  logic          rsp_valid;
  logic          rsp_stall   = 1'b0;
  sse_pkg::rsp_t rsp;
  logic          cfg_wr_en   = 1'b0;
  logic          cfg_wr_data = 1'b0;

  // shadow of the block state
  logic [7:0] oam_shadow [256];
  logic [7:0] oam_addr_shadow;
  logic       tall_shadow;

  sse_pkg::cmd_t cmd_backlog [$];
  sse_pkg::rsp_t expected_rsp [$];
  sse_pkg::rsp_t rsp_want;

  int   errors      = 0;
  int   hold_left   = 0;
  int   quiet_count = 0;
  logic hold_done   = 1'b0;
  logic hold_req    = 1'b0;
  logic quiet       = 1'b0;

  scanline_sprite_evaluation_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void predict_command(input sse_pkg::cmd_t c);
    sse_pkg::rsp_t r;
    logic [7:0]    v;
    logic [8:0]    height;
    logic [8:0]    top;
    logic [8:0]    line9;
    logic [7:0]    base;
    logic [7:0]    slot_bytes [sse_pkg::LINE_SLOTS][4];
    int            found;
    logic          overflow_hit;
    logic          entry0_hit;
    int            e;
    int            k;
    int            j;
    case (c.action)
      sse_pkg::ACT_SET_ADDR: oam_addr_shadow = c.data_byte;
      sse_pkg::ACT_WRITE: begin
        oam_shadow[oam_addr_shadow] = c.data_byte;
        oam_addr_shadow = oam_addr_shadow + 8'd1;
      end
      sse_pkg::ACT_READ: begin
        v = oam_shadow[oam_addr_shadow];
        if (oam_addr_shadow[1:0] == sse_pkg::ATTR_OFFSET) v = v & sse_pkg::ATTR_KEEP_MASK;
        r = '0;
        r.read_data = v;
        r.last = 1'b1;
        expected_rsp.push_back(r);
      end
      sse_pkg::ACT_EVAL: begin
        height = tall_shadow ? sse_pkg::TALL_HEIGHT : sse_pkg::SHORT_HEIGHT;
        line9 = {1'b0, c.line_number};
        found = 0;
        overflow_hit = 1'b0;
        entry0_hit = 1'b0;
        for (k = 0; k < sse_pkg::LINE_SLOTS; k++)
          for (j = 0; j < 4; j++) slot_bytes[k][j] = sse_pkg::EMPTY_BYTE;
        // range end is 9 bits wide, so Y near 255 does not wrap to low lines
        for (e = 0; e < sse_pkg::SPRITE_ENTRIES && !overflow_hit; e++) begin
          base = 8'(e * 4);
          top = {1'b0, oam_shadow[base]};
          if (line9 >= top && line9 < top + height) begin
            if (found >= sse_pkg::LINE_SLOTS) begin
              overflow_hit = 1'b1;
            end else begin
              if (e == 0) entry0_hit = 1'b1;
              for (j = 0; j < 4; j++) slot_bytes[found][j] = oam_shadow[8'(base + j)];
              found++;
            end
          end
        end
        for (k = 0; k < sse_pkg::RECORDS; k++) begin
          r = '0;
          r.kind = 1'b1;
          r.slot_index = 3'(k);
          r.sprite_top = slot_bytes[k][0];
          r.tile_number = slot_bytes[k][1];
          r.attribute_bits = slot_bytes[k][2];
          r.sprite_left = slot_bytes[k][3];
          r.slot_used = (k < found);
          r.sprites_found = 4'(found);
          r.overflow = overflow_hit;
          r.first_entry_in_range = entry0_hit;
          r.last = (k == sse_pkg::RECORDS - 1);
          expected_rsp.push_back(r);
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) predict_command(cmd);
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_backlog.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          cmd <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          rsp_want = expected_rsp.pop_front();
          check_field("kind", 8'(rsp_want.kind), 8'(rsp.kind));
          check_field("read_data", rsp_want.read_data, rsp.read_data);
          check_field("slot_index", 8'(rsp_want.slot_index), 8'(rsp.slot_index));
          check_field("sprite_top", rsp_want.sprite_top, rsp.sprite_top);
          check_field("tile_number", rsp_want.tile_number, rsp.tile_number);
          check_field("attribute_bits", rsp_want.attribute_bits, rsp.attribute_bits);
          check_field("sprite_left", rsp_want.sprite_left, rsp.sprite_left);
          check_field("slot_used", 8'(rsp_want.slot_used), 8'(rsp.slot_used));
          check_field("sprites_found", 8'(rsp_want.sprites_found), 8'(rsp.sprites_found));
          check_field("overflow", 8'(rsp_want.overflow), 8'(rsp.overflow));
          check_field("first_entry_in_range", 8'(rsp_want.first_entry_in_range),
                      8'(rsp.first_entry_in_range));
          check_field("last", 8'(rsp_want.last), 8'(rsp.last));
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic push_cmd(input logic [1:0] act, input logic [7:0] data,
                          input logic [7:0] line);
    sse_pkg::cmd_t c;
    c.action = act;
    c.data_byte = data;
    c.line_number = line;
    cmd_backlog.push_back(c);
  endtask

  // unused fields get random values so their bits toggle too
  task automatic push_set_addr(input logic [7:0] addr);
    push_cmd(sse_pkg::ACT_SET_ADDR, addr, 8'($urandom));
  endtask

  task automatic push_write(input logic [7:0] data);
    push_cmd(sse_pkg::ACT_WRITE, data, 8'($urandom));
  endtask

  task automatic push_read();
    push_cmd(sse_pkg::ACT_READ, 8'($urandom), 8'($urandom));
  endtask

  task automatic push_eval(input logic [7:0] line);
    push_cmd(sse_pkg::ACT_EVAL, 8'($urandom), line);
  endtask

  task automatic push_sprite(input logic [5:0] entry, input logic [7:0] y,
                             input logic [7:0] tile, input logic [7:0] attr,
                             input logic [7:0] x);
    push_set_addr({entry, 2'b00});
    push_write(y);
    push_write(tile);
    push_write(attr);
    push_write(x);
  endtask

  task automatic write_tall(input logic v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tall_shadow = v;
  endtask

  // wait until every command is taken and every result beat is back
  task automatic drain_and_settle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || expected_rsp.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly sprite loads clustered in one Y band, evaluated near that band
  task automatic random_phase(input int items);
    int         made;
    int         pick;
    int         n;
    logic [7:0] band;
    logic [5:0] entry;
    logic [7:0] y;
    band = 8'($urandom_range(200, 16));
    made = 0;
    while (made < items) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        entry = ($urandom_range(9) == 0) ? 6'd0 : 6'($urandom_range(63));
        y = ($urandom_range(4) == 0) ? 8'($urandom) : band + 8'($urandom_range(20));
        push_sprite(entry, y, 8'($urandom), 8'($urandom), 8'($urandom));
        made += 5;
      end else if (pick < 65) begin
        if ($urandom_range(3) == 0) push_eval(8'($urandom));
        else push_eval(band - 8'd4 + 8'($urandom_range(36)));
        made += 1;
      end else if (pick < 80) begin
        push_set_addr(8'($urandom));
        n = $urandom_range(3, 1);
        repeat (n) push_read();
        made += n + 1;
      end else if (pick < 90) begin
        // broken load: random start, short run of writes
        push_set_addr(8'($urandom));
        n = $urandom_range(3, 1);
        repeat (n) push_write(8'($urandom));
        made += n + 1;
      end else begin
        push_cmd(2'($urandom), 8'($urandom), 8'($urandom));
        made += 1;
      end
    end
  endtask

  initial begin
    foreach (oam_shadow[i]) oam_shadow[i] = 8'h00;
    oam_addr_shadow = 8'h00;
    tall_shadow = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    // memory clear runs after reset
    do @(negedge clk);
    while (cmd_stall);
    write_tall(1'b0);

    // directed, 8-line sprites
    @(negedge clk);
    push_read();
    push_eval(8'd0);     // every entry at Y=0 matches: slots full, overflow
    push_eval(8'd255);   // nothing matches, all slots empty
    push_set_addr(8'hFF);
    push_write(8'hAA);   // address wraps to 0 after this
    push_write(8'hFF);
    push_write(8'h7C);
    push_write(8'hFF);
    push_write(8'h00);
    push_eval(8'd255);   // only entry 0 at Y=255
    push_eval(8'd3);     // entry 0 must not wrap into low lines
    push_set_addr(8'h02);
    push_read();         // attribute byte, bits 2-4 masked
    push_read();         // address unchanged by a read
    push_set_addr(8'hFF);
    push_read();
    push_set_addr(8'h01);
    push_read();
    drain_and_settle();

    // directed, 16-line sprites
    write_tall(1'b1);
    @(negedge clk);
    push_set_addr(8'h04);
    push_write(8'hF0);
    push_eval(8'd255);
    push_eval(8'd15);
    push_eval(8'd16);
    drain_and_settle();

    // random, no idling on either side
    write_tall(1'b0);
    @(negedge clk);
    quiet = 1'b1;
    random_phase(PHASE_ITEMS);
    drain_and_settle();
    @(negedge clk);
    quiet = 1'b0;

    // random, receiver holds off while commands keep coming
    write_tall(1'b1);
    @(negedge clk);
    hold_req = 1'b1;
    random_phase(PHASE_ITEMS);
    drain_and_settle();

    write_tall(1'b0);
    @(negedge clk);
    random_phase(PHASE_ITEMS);
    drain_and_settle();

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
